[sv/chth_pkg.sv]
// ----------------------------------------------------------------------------
// chth_pkg: shared types and constants of the chained hash table
// Opcodes, status codes, controller states and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package chth_pkg;

  localparam int unsigned MAX_BUCKETS  = 16;
  localparam int unsigned POOL_NODES   = 64;
  localparam int unsigned HASH_MODULUS = 1000;

  // configuration register indexes
  localparam logic [1:0] CFG_HASH_MULT    = 2'd0;
  localparam logic [1:0] CFG_HASH_ADD     = 2'd1;
  localparam logic [1:0] CFG_BUCKET_COUNT = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_MODM,
    S_NINIT,
    S_MODN,
    S_DISP,
    S_SCAN,
    S_INS_WALK,
    S_INS_CHK,
    S_WALK,
    S_CMP,
    S_RESP
  } state_e;

  typedef struct packed {
    logic    load;       // capture the input word
    logic    mul;        // load the offset key into the reducer
    logic    add;        // start the mod-modulus step sequence
    logic    modm;       // one step of the mod-modulus reduction
    logic    modn_init;  // start the mod-bucket-count reduction
    logic    modn;       // one bit of the mod-bucket-count reduction
    logic    head;       // load chain pointer from bucket head
    logic    scan_clr;   // restart the free-node scan
    logic    scan;       // advance the free-node scan
    logic    alloc;      // claim the scanned node and fill it
    logic    head_f;     // point the bucket head at the new node
    logic    advance;    // follow the link of the current node
    logic    link_tail;  // hang the new node off the current node
    logic    unlink;     // drop the current node from its chain
    logic    res_set;    // latch the result word
    status_e res_status;
    logic    res_hit;    // result value comes from the node data
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       cnt_last;
    logic       scan_end;
    logic       free;
    logic       p_live;
    logic       steps_end;
    logic       key_hit;
    logic       nxt_live;
  } sts_t;

endpackage

[sv/chth_ctrl.sv]
// ----------------------------------------------------------------------------
// chth_ctrl: operation sequencer
// Steps one operation through hashing, node allocation and the chain walk,
// and issues one command bundle to the datapath each cycle.
// ----------------------------------------------------------------------------
module chth_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  chth_pkg::sts_t sts_i,
  output chth_pkg::cmd_t cmd_o,
  output logic           busy_o,
  output logic           done_o
);

  chth_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chth_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_status = chth_pkg::ST_OK;
    unique case (state_q)
      chth_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = chth_pkg::S_MUL;
        end
      end
      chth_pkg::S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = chth_pkg::S_ADD;
      end
      chth_pkg::S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = chth_pkg::S_MODM;
      end
      chth_pkg::S_MODM: begin
        cmd_o.modm = 1'b1;
        if (sts_i.cnt_last) state_d = chth_pkg::S_NINIT;
      end
      chth_pkg::S_NINIT: begin
        cmd_o.modn_init = 1'b1;
        state_d         = chth_pkg::S_MODN;
      end
      chth_pkg::S_MODN: begin
        cmd_o.modn = 1'b1;
        if (sts_i.cnt_last) state_d = chth_pkg::S_DISP;
      end
      chth_pkg::S_DISP: begin
        cmd_o.head     = 1'b1;
        cmd_o.scan_clr = 1'b1;
        case (sts_i.op) inside
          chth_pkg::OP_INSERT: state_d = chth_pkg::S_SCAN;
          chth_pkg::OP_LOOKUP, chth_pkg::OP_REMOVE: state_d = chth_pkg::S_WALK;
          default: begin
            cmd_o.res_set = 1'b1;
            state_d       = chth_pkg::S_RESP;
          end
        endcase
      end
      // find the lowest free node
      chth_pkg::S_SCAN: begin
        if (sts_i.scan_end) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = chth_pkg::ST_FULL;
          state_d          = chth_pkg::S_RESP;
        end else if (sts_i.free) begin
          cmd_o.alloc = 1'b1;
          state_d     = chth_pkg::S_INS_WALK;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      chth_pkg::S_INS_WALK: begin
        if (!sts_i.p_live) begin
          cmd_o.head_f  = 1'b1;
          cmd_o.res_set = 1'b1;
          state_d       = chth_pkg::S_RESP;
        end else begin
          state_d = chth_pkg::S_INS_CHK;
        end
      end
      // walk to the tail, then append
      chth_pkg::S_INS_CHK: begin
        if (sts_i.nxt_live && !sts_i.steps_end) begin
          cmd_o.advance = 1'b1;
          state_d       = chth_pkg::S_INS_WALK;
        end else begin
          cmd_o.link_tail = 1'b1;
          cmd_o.res_set   = 1'b1;
          state_d         = chth_pkg::S_RESP;
        end
      end
      chth_pkg::S_WALK: begin
        if (!sts_i.p_live || sts_i.steps_end) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = chth_pkg::ST_MISS;
          state_d          = chth_pkg::S_RESP;
        end else begin
          state_d = chth_pkg::S_CMP;
        end
      end
      chth_pkg::S_CMP: begin
        if (sts_i.key_hit) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_hit = (sts_i.op == chth_pkg::OP_LOOKUP);
          cmd_o.unlink  = (sts_i.op == chth_pkg::OP_REMOVE);
          state_d       = chth_pkg::S_RESP;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = chth_pkg::S_WALK;
        end
      end
      chth_pkg::S_RESP: begin
        state_d = chth_pkg::S_IDLE;
      end
      default: state_d = chth_pkg::S_IDLE;
    endcase
  end

  assign busy_o = (state_q != chth_pkg::S_IDLE);
  assign done_o = (state_q == chth_pkg::S_RESP);

endmodule

[sv/chth_dp.sv]
// ----------------------------------------------------------------------------
// chth_dp: hash and node pool datapath
// Universal hash reduced by reciprocal multiplication and a bit-serial
// bucket-count remainder, bucket heads, allocation map and the node
// memories, driven by the sequencer's command bundle.
// ----------------------------------------------------------------------------
module chth_dp #(
  parameter int unsigned MAX_BUCKETS  = chth_pkg::MAX_BUCKETS,
  parameter int unsigned POOL_NODES   = chth_pkg::POOL_NODES,
  parameter int unsigned HASH_MODULUS = chth_pkg::HASH_MODULUS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  chth_pkg::cmd_t        cmd_i,
  output chth_pkg::sts_t        sts_o,
  input  logic [9:0]            hash_mult_i,
  input  logic [9:0]            hash_add_i,
  input  logic [4:0]            bucket_count_i,
  input  logic [1:0]            opcode_i,
  input  logic signed [31:0]    item_key_i,
  input  logic signed [31:0]    item_value_i,
  output logic [1:0]            status_o,
  output logic signed [31:0]    found_value_o
);

  localparam int unsigned NW   = $clog2(POOL_NODES + 1);
  localparam int unsigned AW   = $clog2(POOL_NODES);
  localparam int unsigned BIW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned CW   = BIW + 1;
  localparam int unsigned RW   = $clog2(HASH_MODULUS) + 1;
  localparam int unsigned CNTW = $clog2((RW > 8) ? RW : 8);
  localparam logic [NW-1:0] NIL = NW'(POOL_NODES);
  localparam logic [RW-1:0] MODV = RW'(HASH_MODULUS);
  // floor(2^32 / modulus): the quotient estimate is exact or one low
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / HASH_MODULUS);
  // modulus minus (2^31 mod modulus): undoes the sign offset of the key
  localparam logic [RW-1:0] KEY_ADJ =
    RW'(HASH_MODULUS - ((64'd1 << 31) % HASH_MODULUS));

  // mod-modulus steps, counted down: reduce the key, then the hash sum
  localparam logic [CNTW-1:0] STP_KMUL = CNTW'(7);
  localparam logic [CNTW-1:0] STP_KQM  = CNTW'(6);
  localparam logic [CNTW-1:0] STP_KSUB = CNTW'(5);
  localparam logic [CNTW-1:0] STP_KADJ = CNTW'(4);
  localparam logic [CNTW-1:0] STP_HASH = CNTW'(3);
  localparam logic [CNTW-1:0] STP_HMUL = CNTW'(2);
  localparam logic [CNTW-1:0] STP_HQM  = CNTW'(1);
  localparam logic [CNTW-1:0] STP_HSUB = CNTW'(0);

  logic [1:0]         op_q;
  logic [31:0]        key_q, val_q;
  logic [31:0]        a_q, rq_q, qm_q;
  logic [RW-1:0]      r1_q, rs_q;
  logic [CW-1:0]      r2_q, r2_sh, n_eff;
  logic [CNTW-1:0]    cnt_q;
  logic [BIW-1:0]     bkt;
  logic [NW-1:0]      p_q, prev_q, steps_q, scan_q, nxt;
  logic [NW-1:0]      head_q [MAX_BUCKETS];
  logic [POOL_NODES-1:0] in_use_q;
  logic [31:0]        key_mem  [POOL_NODES];
  logic [31:0]        data_mem [POOL_NODES];
  logic [NW-1:0]      link_mem [POOL_NODES];
  logic [31:0]        rd_key_q, rd_data_q;
  logic [NW-1:0]      rd_link_q;
  logic               link_we;
  logic [NW-1:0]      link_wa, link_wd;
  logic               p_live, nxt_live;

  // bring a value below twice the modulus into range
  function automatic logic [RW-1:0] mod_fix(logic [RW-1:0] v);
    return (v >= MODV) ? v - MODV : v;
  endfunction

  // effective bucket count: zero acts as one, saturate at the maximum
  always_comb begin
    if (bucket_count_i == 5'd0) begin
      n_eff = CW'(1);
    end else if ({4'd0, bucket_count_i} > 9'(MAX_BUCKETS)) begin
      n_eff = CW'(MAX_BUCKETS);
    end else begin
      n_eff = CW'(bucket_count_i);
    end
  end

  assign r2_sh = {r2_q[CW-2:0], rs_q[RW-1]};
  assign bkt   = r2_q[BIW-1:0];

  // hash unit: key mod modulus, then (mult * key + add) mod modulus,
  // then restoring reduction by the bucket count one bit a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      key_q <= item_key_i;
      val_q <= item_value_i;
    end
    if (cmd_i.mul) a_q <= key_q ^ 32'h8000_0000;
    if (cmd_i.add) cnt_q <= STP_KMUL;
    if (cmd_i.modm) begin
      case (cnt_q) inside
        STP_KMUL, STP_HMUL: rq_q <= 32'(({32'd0, a_q} * {32'd0, RECIP}) >> 32);
        STP_KQM, STP_HQM:   qm_q <= 32'(rq_q * 32'(HASH_MODULUS));
        STP_KSUB, STP_HSUB: r1_q <= mod_fix(RW'(a_q - qm_q));
        STP_KADJ:           r1_q <= mod_fix(r1_q + KEY_ADJ);
        STP_HASH:           a_q  <= 32'(hash_mult_i) * 32'(r1_q) + 32'(hash_add_i);
        default: ;
      endcase
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.modn_init) begin
      rs_q  <= r1_q;
      r2_q  <= '0;
      cnt_q <= CNTW'(RW - 1);
    end
    if (cmd_i.modn) begin
      rs_q  <= rs_q << 1;
      r2_q  <= (r2_sh >= n_eff) ? r2_sh - n_eff : r2_sh;
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign p_live   = (p_q < NIL) && in_use_q[p_q[AW-1:0]];
  assign nxt_live = (rd_link_q < NIL) && in_use_q[rd_link_q[AW-1:0]];
  assign nxt      = nxt_live ? rd_link_q : NIL;

  // chain pointer, walk bound and free-node scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.head) begin
      p_q     <= head_q[bkt];
      prev_q  <= NIL;
      steps_q <= '0;
    end
    if (cmd_i.advance) begin
      prev_q  <= p_q;
      p_q     <= rd_link_q;
      steps_q <= steps_q + 1'b1;
    end
    if (cmd_i.scan_clr) scan_q <= '0;
    if (cmd_i.scan)     scan_q <= scan_q + 1'b1;
  end

  // bucket heads and allocation map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_BUCKETS; i++) head_q[i] <= NIL;
      in_use_q <= '0;
    end else begin
      if (cmd_i.alloc) in_use_q[scan_q[AW-1:0]] <= 1'b1;
      if (cmd_i.head_f) head_q[bkt] <= scan_q;
      if (cmd_i.unlink) begin
        in_use_q[p_q[AW-1:0]] <= 1'b0;
        if (prev_q == NIL) head_q[bkt] <= nxt;
      end
    end
  end

  // link port: fill a new node, append at the tail, or bridge a removed node
  always_comb begin
    link_we = 1'b0;
    link_wa = scan_q;
    link_wd = NIL;
    if (cmd_i.alloc) begin
      link_we = 1'b1;
    end else if (cmd_i.link_tail) begin
      link_we = 1'b1;
      link_wa = p_q;
      link_wd = scan_q;
    end else if (cmd_i.unlink && prev_q != NIL) begin
      link_we = 1'b1;
      link_wa = prev_q;
      link_wd = nxt;
    end
  end

  // node memories, read data registered at the chain pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) begin
      key_mem[scan_q[AW-1:0]]  <= key_q;
      data_mem[scan_q[AW-1:0]] <= val_q;
    end
    if (link_we) link_mem[link_wa[AW-1:0]] <= link_wd;
    rd_key_q  <= key_mem[p_q[AW-1:0]];
    rd_data_q <= data_mem[p_q[AW-1:0]];
    rd_link_q <= link_mem[p_q[AW-1:0]];
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      status_o      <= cmd_i.res_status;
      found_value_o <= cmd_i.res_hit ? rd_data_q : '1;
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.cnt_last  = (cnt_q == '0);
  assign sts_o.scan_end  = (scan_q == NIL);
  assign sts_o.free      = !in_use_q[scan_q[AW-1:0]];
  assign sts_o.p_live    = p_live;
  assign sts_o.steps_end = (steps_q == NIL);
  assign sts_o.key_hit   = (rd_key_q == key_q);
  assign sts_o.nxt_live  = nxt_live;

endmodule

[sv/chained_hash_table_unit.sv]
// ----------------------------------------------------------------------------
// chained_hash_table_unit: key-value table with separate chaining
// Insert, lookup and remove over a fixed node pool, bucket chosen by a
// universal hash reduced modulo a constant and then the bucket count.
// ----------------------------------------------------------------------------
// One operation at a time: start is taken while busy is low, and the result
// word shows on status_o and found_value_o for the single cycle in which
// done_o is high; the receiver cannot stall it. Hashing runs eight reduction
// steps by reciprocal multiplication, then a bit-serial remainder by the
// bucket count. After that insert scans past the used nodes below the first
// free one, claims it and walks the chain to its tail; lookup and remove
// walk the chain node by node. busy falls the cycle after done_o. Hash
// registers must be written only while busy is low; the block itself does
// not enforce it.
module chained_hash_table_unit #(
  parameter int unsigned MAX_BUCKETS  = chth_pkg::MAX_BUCKETS,
  parameter int unsigned POOL_NODES   = chth_pkg::POOL_NODES,
  parameter int unsigned HASH_MODULUS = chth_pkg::HASH_MODULUS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [9:0]         cfg_wdata_i,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] item_key_i,
  input  logic signed [31:0] item_value_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] found_value_o
);

  logic [9:0]     hash_mult_q, hash_add_q;
  logic [4:0]     bucket_count_q;
  chth_pkg::cmd_t cmd;
  chth_pkg::sts_t sts;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_mult_q    <= 10'd1;
      hash_add_q     <= 10'd0;
      bucket_count_q <= 5'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        chth_pkg::CFG_HASH_MULT:    hash_mult_q    <= cfg_wdata_i;
        chth_pkg::CFG_HASH_ADD:     hash_add_q     <= cfg_wdata_i;
        chth_pkg::CFG_BUCKET_COUNT: bucket_count_q <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  chth_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  chth_dp #(
    .MAX_BUCKETS  (MAX_BUCKETS),
    .POOL_NODES   (POOL_NODES),
    .HASH_MODULUS (HASH_MODULUS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .hash_mult_i    (hash_mult_q),
    .hash_add_i     (hash_add_q),
    .bucket_count_i (bucket_count_q),
    .opcode_i       (opcode_i),
    .item_key_i     (item_key_i),
    .item_value_i   (item_value_i),
    .status_o       (status_o),
    .found_value_o  (found_value_o)
  );

  // an accepted word keeps the unit busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  // a result word lasts one cycle and frees the unit
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result word held or unit not released");

  // a result never carries the unused status code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o != 2'd3)
    else $error("invalid status code");

  // a result other than OK carries all ones; only lookup hits return data
  a_miss_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != chth_pkg::ST_OK |-> found_value_o == '1)
    else $error("miss carried a value");

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for chained_hash_table_unit
// Drives insert, lookup, remove and unused-opcode words in random bursts. A behavioral copy
// of the table predicts each result, and every done word is checked against
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int NIL = int'(chth_pkg::POOL_NODES);
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value;
  } rsp_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [9:0]         cfg_wdata_i = '0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         opcode_i = '0;
  logic signed [31:0] item_key_i = '0;
  logic signed [31:0] item_value_i = '0;
  logic               done_o;
  logic [1:0]         status_o;
  logic signed [31:0] found_value_o;

  chained_hash_table_unit u_top (.*);

  // model state
  int unsigned mdl_mult, mdl_add, mdl_nbkt;
  int          mdl_head [chth_pkg::MAX_BUCKETS];
  logic [31:0] mdl_key  [chth_pkg::POOL_NODES];
  logic [31:0] mdl_data [chth_pkg::POOL_NODES];
  int          mdl_link [chth_pkg::POOL_NODES];
  bit          mdl_used [chth_pkg::POOL_NODES];

  cmd_word_t pending_words [$];
  rsp_word_t expected_rsp [$];
  int        n_errors = 0;
  bit        hold_send = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit node_live(int p);
    return p < NIL && mdl_used[p];
  endfunction

  function automatic int bucket_of(logic signed [31:0] key);
    longint x;
    longint r;
    int n;
    x = longint'(mdl_mult) * longint'(key) + longint'(mdl_add);
    r = x % longint'(chth_pkg::HASH_MODULUS);
    if (r < 0) r += longint'(chth_pkg::HASH_MODULUS);
    n = mdl_nbkt;
    if (n == 0) n = 1;
    if (n > int'(chth_pkg::MAX_BUCKETS)) n = int'(chth_pkg::MAX_BUCKETS);
    return int'(r % n);
  endfunction

  // compute the result word of one command and update the table
  function automatic rsp_word_t apply_table_op(cmd_word_t c);
    rsp_word_t r;
    int b, p, prev, f, steps, nxt;
    r.status = chth_pkg::ST_OK;
    r.value = -1;
    b = bucket_of(c.key);
    if (c.op == chth_pkg::OP_INSERT) begin
      f = NIL;
      for (int i = 0; i < NIL; i++)
        if (!mdl_used[i]) begin
          f = i;
          break;
        end
      if (f == NIL) begin
        r.status = chth_pkg::ST_FULL;
      end else begin
        mdl_used[f] = 1'b1;
        mdl_key[f] = c.key;
        mdl_data[f] = c.value;
        mdl_link[f] = NIL;
        p = mdl_head[b];
        if (!node_live(p)) begin
          mdl_head[b] = f;
        end else begin
          steps = 0;
          while (node_live(mdl_link[p]) && steps < NIL) begin
            p = mdl_link[p];
            steps++;
          end
          mdl_link[p] = f;
        end
      end
    end else if (c.op == chth_pkg::OP_LOOKUP) begin
      r.status = chth_pkg::ST_MISS;
      p = mdl_head[b];
      for (steps = 0; node_live(p) && steps < NIL; steps++) begin
        if (mdl_key[p] == c.key) begin
          r.status = chth_pkg::ST_OK;
          r.value = mdl_data[p];
          break;
        end
        p = mdl_link[p];
      end
    end else if (c.op == chth_pkg::OP_REMOVE) begin
      r.status = chth_pkg::ST_MISS;
      prev = NIL;
      p = mdl_head[b];
      for (steps = 0; node_live(p) && steps < NIL; steps++) begin
        if (mdl_key[p] == c.key) begin
          nxt = mdl_link[p];
          if (!node_live(nxt)) nxt = NIL;
          if (prev == NIL) mdl_head[b] = nxt;
          else mdl_link[prev] = nxt;
          mdl_used[p] = 1'b0;
          r.status = chth_pkg::ST_OK;
          break;
        end
        prev = p;
        p = mdl_link[p];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    n_errors++;
  endtask

  // drive command words in bursts with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_rsp.push_back(apply_table_op({opcode_i, item_key_i, item_value_i}));
      end
      if (start && busy) begin
        // hold the word until accepted
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_words.size() > 0 && !hold_send) begin
        cmd_word_t w;
        w = pending_words.pop_front();
        start <= 1'b1;
        opcode_i <= w.op;
        item_key_i <= w.key;
        item_value_i <= w.value;
        if (burst_left <= 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // check each done word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("done word with nothing expected");
      end else begin
        rsp_word_t e;
        e = expected_rsp.pop_front();
        if (status_o !== e.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, e.status));
        if (found_value_o !== e.value)
          report_mismatch($sformatf("value %0d, expected %0d", found_value_o, e.value));
      end
    end
  end

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -1;
      3: return 0;
      default: return $urandom;
    endcase
  endfunction

  // wait until the block is idle with nothing expected
  task automatic drain();
    while (pending_words.size() > 0 || start || busy || expected_rsp.size() > 0)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == chth_pkg::CFG_HASH_MULT) mdl_mult = data;
    else if (idx == chth_pkg::CFG_HASH_ADD) mdl_add = data;
    else if (idx == chth_pkg::CFG_BUCKET_COUNT) mdl_nbkt = data[4:0];
  endtask

  task automatic push_op(logic [1:0] op, logic signed [31:0] k, logic signed [31:0] v);
    pending_words.push_back({op, k, v});
  endtask

  // random traffic over a small key set so chains, hits and removes occur
  task automatic random_phase(int count);
    logic signed [31:0] keys [8];
    int pick;
    foreach (keys[i]) keys[i] = rand_word();
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) push_op(chth_pkg::OP_INSERT, keys[$urandom_range(0, 7)], rand_word());
      else if (pick < 70) push_op(chth_pkg::OP_LOOKUP, keys[$urandom_range(0, 7)], rand_word());
      else if (pick < 93) push_op(chth_pkg::OP_REMOVE, keys[$urandom_range(0, 7)], rand_word());
      else if (pick < 97) push_op(2'($urandom_range(0, 2)), rand_word(), rand_word());
      else push_op(OP_UNUSED, rand_word(), rand_word());
    end
  endtask

  initial begin
    mdl_mult = 1;
    mdl_add = 0;
    mdl_nbkt = 10;
    foreach (mdl_head[i]) mdl_head[i] = NIL;
    foreach (mdl_used[i]) mdl_used[i] = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every opcode, misses, duplicates
    push_op(chth_pkg::OP_LOOKUP, 32'sd5, 0);
    push_op(chth_pkg::OP_REMOVE, 32'sd5, 0);
    push_op(chth_pkg::OP_INSERT, 32'sh8000_0000, 32'sh7fff_ffff);
    push_op(chth_pkg::OP_INSERT, 32'sh7fff_ffff, 32'sh8000_0000);
    push_op(chth_pkg::OP_INSERT, -1, -1);
    push_op(chth_pkg::OP_INSERT, 32'sd5, 32'sd1);
    push_op(chth_pkg::OP_INSERT, 32'sd5, 32'sd2);
    push_op(chth_pkg::OP_INSERT, 32'sd15, 32'sd3);
    push_op(chth_pkg::OP_LOOKUP, 32'sd5, 0);
    push_op(chth_pkg::OP_LOOKUP, 32'sh8000_0000, 0);
    push_op(chth_pkg::OP_REMOVE, 32'sd5, 0);
    push_op(chth_pkg::OP_LOOKUP, 32'sd5, 0);
    push_op(chth_pkg::OP_REMOVE, 32'sd15, 0);
    push_op(chth_pkg::OP_LOOKUP, 32'sd25, 0);
    push_op(OP_UNUSED, -1, -1);
    push_op(chth_pkg::OP_REMOVE, -1, 0);
    drain();

    // pool exhaustion with one bucket
    write_reg(chth_pkg::CFG_BUCKET_COUNT, 10'd0);
    for (int i = 0; i < NIL; i++) push_op(chth_pkg::OP_INSERT, i, $urandom);
    push_op(chth_pkg::OP_INSERT, 32'sd99, 32'sd99);
    push_op(chth_pkg::OP_LOOKUP, 32'sd40, 0);
    push_op(chth_pkg::OP_REMOVE, 32'sd0, 0);
    push_op(chth_pkg::OP_INSERT, 32'sd77, 32'sd7);
    drain();

    // change settings with nodes stored, no rehash
    write_reg(chth_pkg::CFG_HASH_MULT, 10'd999);
    write_reg(chth_pkg::CFG_HASH_ADD, 10'd999);
    write_reg(chth_pkg::CFG_BUCKET_COUNT, 10'd16);
    for (int i = 0; i < 70; i++)
      push_op(chth_pkg::OP_REMOVE, i, 0);
    random_phase(80);
    drain();

    write_reg(chth_pkg::CFG_HASH_MULT, 10'h3ff);
    write_reg(chth_pkg::CFG_HASH_ADD, 10'h3ff);
    write_reg(chth_pkg::CFG_BUCKET_COUNT, 10'h1f);
    random_phase(120);
    drain();

    write_reg(chth_pkg::CFG_HASH_MULT, 10'd0);
    write_reg(chth_pkg::CFG_HASH_ADD, 10'd0);
    write_reg(chth_pkg::CFG_BUCKET_COUNT, 10'd1);
    random_phase(100);
    drain();

    for (int ph = 0; ph < 2; ph++) begin
      write_reg(chth_pkg::CFG_HASH_MULT, 10'($urandom_range(1, 999)));
      write_reg(chth_pkg::CFG_HASH_ADD, 10'($urandom_range(0, 999)));
      write_reg(chth_pkg::CFG_BUCKET_COUNT, 10'($urandom_range(2, 16)));
      random_phase(60);
      // pause sending until everything has come back, then resume
      hold_send = 1'b1;
      while (start || busy || expected_rsp.size() > 0) @(posedge clk_i);
      hold_send = 1'b0;
      random_phase(40);
      drain();
    end

    if (n_errors == 0) begin
      $display("** chained_hash_table_unit: PASSED **");
    end else begin
      $display("** chained_hash_table_unit: FAILED **");
    end
    $finish;
  end

  // bound the run
  initial begin
    #8000000;
    $display("** chained_hash_table_unit: FAILED **");
    $finish;
  end

endmodule

[sim.f]
sv/chth_pkg.sv
sv/chth_ctrl.sv
sv/chth_dp.sv
sv/chained_hash_table_unit.sv
tb/sv/tb.sv
